[rtl/core/egsd_pkg.sv]
// Shared types, codes and coded-block-pattern tables for the exp-Golomb decoder.
// No dependencies; every other file of the decoder refers to this package.
package egsd_pkg;

	localparam int WindowWidth   = 64;
	localparam int ValueWidth    = 33;
	localparam int LenWidth      = 6;
	localparam int CodeNumWidth  = 32;
	localparam int ZerosWidth    = 5;
	localparam int SmallTableSize = 16;
	localparam int LargeTableSize = 48;

	// Decode modes
	typedef enum logic [1:0] {
		FUNC_UE = 2'd0,
		FUNC_SE = 2'd1,
		FUNC_TE = 2'd2,
		FUNC_ME = 2'd3
	} func_t;

	// Chroma array types that select the small table
	localparam logic [1:0] ChromaMono = 2'd0;
	localparam logic [1:0] Chroma444  = 2'd3;

	// me table columns
	localparam logic ColIntra = 1'b0;

	// Leading-zero count and code number of one exp-Golomb code
	typedef struct packed {
		logic [CodeNumWidth-1:0] code_num;
		logic [ZerosWidth-1:0]   zeros;
		logic                    overflow;
	} code_t;

	// One decoded syntax element
	typedef struct packed {
		logic signed [ValueWidth-1:0] value;
		logic [LenWidth-1:0]          bits_used;
		logic                         code_error;
	} res_t;

	// Coded-block-pattern table, chroma format 1 or 2
	localparam logic [5:0] CbpLargeIntra [LargeTableSize] = '{
		6'd47, 6'd31, 6'd15, 6'd0,  6'd23, 6'd27, 6'd29, 6'd30,
		6'd7,  6'd11, 6'd13, 6'd14, 6'd39, 6'd43, 6'd45, 6'd46,
		6'd16, 6'd3,  6'd5,  6'd10, 6'd12, 6'd19, 6'd21, 6'd26,
		6'd28, 6'd35, 6'd37, 6'd42, 6'd44, 6'd1,  6'd2,  6'd4,
		6'd8,  6'd17, 6'd18, 6'd20, 6'd24, 6'd6,  6'd9,  6'd22,
		6'd25, 6'd32, 6'd33, 6'd34, 6'd36, 6'd40, 6'd38, 6'd41
	};
	localparam logic [5:0] CbpLargeInter [LargeTableSize] = '{
		6'd0,  6'd16, 6'd1,  6'd2,  6'd4,  6'd8,  6'd32, 6'd3,
		6'd5,  6'd10, 6'd12, 6'd15, 6'd47, 6'd7,  6'd11, 6'd13,
		6'd14, 6'd6,  6'd9,  6'd31, 6'd35, 6'd37, 6'd42, 6'd44,
		6'd33, 6'd34, 6'd36, 6'd40, 6'd39, 6'd43, 6'd45, 6'd46,
		6'd17, 6'd18, 6'd20, 6'd24, 6'd19, 6'd21, 6'd26, 6'd28,
		6'd23, 6'd27, 6'd29, 6'd30, 6'd22, 6'd25, 6'd38, 6'd41
	};

	// Coded-block-pattern table, chroma format 0 or 3
	localparam logic [3:0] CbpSmallIntra [SmallTableSize] = '{
		4'd15, 4'd0, 4'd7, 4'd11, 4'd13, 4'd14, 4'd3, 4'd5,
		4'd10, 4'd12, 4'd1, 4'd2, 4'd4, 4'd8, 4'd6, 4'd9
	};
	localparam logic [3:0] CbpSmallInter [SmallTableSize] = '{
		4'd0, 4'd1, 4'd2, 4'd4, 4'd8, 4'd3, 4'd5, 4'd10,
		4'd12, 4'd15, 4'd7, 4'd11, 4'd13, 4'd14, 4'd6, 4'd9
	};

endpackage

[rtl/core/egsd_in_if.sv]
// Input channel of the exp-Golomb decoder: valid/ready plus one request beat.
// Depends on egsd_pkg for field widths.
interface egsd_in_if;
	logic                                valid;
	logic                                ready;
	logic [1:0]                          func;
	logic [egsd_pkg::WindowWidth-1:0]    bit_window;
	logic [5:0]                          te_range;
	logic [1:0]                          chroma_format;
	logic                                inter_column;

	modport source (output valid, func, bit_window, te_range, chroma_format,
		inter_column, input ready);
	modport sink (input valid, func, bit_window, te_range, chroma_format,
		inter_column, output ready);
endinterface

[rtl/core/egsd_out_if.sv]
// Output channel of the exp-Golomb decoder: valid/ready plus one result beat.
// Depends on egsd_pkg for field widths.
interface egsd_out_if;
	logic                                       valid;
	logic                                       ready;
	logic signed [egsd_pkg::ValueWidth-1:0]     value;
	logic [egsd_pkg::LenWidth-1:0]              bits_used;
	logic                                       code_error;

	modport source (output valid, value, bits_used, code_error, input ready);
	modport sink (input valid, value, bits_used, code_error, output ready);
endinterface

[rtl/core/egsd_codenum.sv]
// Leading-zero count and code-number extraction for one exp-Golomb code.
// Depends on egsd_pkg (code_t, widths).
module egsd_codenum (
	input  logic [egsd_pkg::WindowWidth-1:0] bit_window,
	output egsd_pkg::code_t                  code
);

	logic [31:0]                          top;
	logic [31:0]                          x1, x2, x3, x4;
	logic [egsd_pkg::ZerosWidth-1:0]      lz;
	logic [5:0]                           shamt;
	logic [egsd_pkg::WindowWidth-1:0]     code_wide;

	assign top = bit_window[63:32];

	// Count leading zeros of the upper half in five halving steps
	always_comb begin
		lz[4] = (top[31:16] == 16'd0);
		x1    = lz[4] ? {top[15:0], 16'd0} : top;
		lz[3] = (x1[31:24] == 8'd0);
		x2    = lz[3] ? {x1[23:0], 8'd0} : x1;
		lz[2] = (x2[31:28] == 4'd0);
		x3    = lz[2] ? {x2[27:0], 4'd0} : x2;
		lz[1] = (x3[31:30] == 2'd0);
		x4    = lz[1] ? {x3[29:0], 2'd0} : x3;
		lz[0] = ~x4[31];
	end

	// Right-align the 2L+1 bit code: shift by 63 - 2L
	assign shamt     = ~{lz, 1'b0};
	assign code_wide = bit_window >> shamt;

	assign code.code_num = code_wide[egsd_pkg::CodeNumWidth-1:0] - 32'd1;
	assign code.zeros    = lz;
	assign code.overflow = (top == 32'd0);

endmodule

[rtl/core/egsd_map.sv]
// Maps a code number to the syntax element value by decode mode (ue/se/te/me).
// Depends on egsd_pkg (code_t, res_t, func_t, coded-block-pattern tables).
module egsd_map (
	input  logic [1:0]      func,
	input  logic [5:0]      te_range,
	input  logic [1:0]      chroma_format,
	input  logic            inter_column,
	input  logic            first_bit,
	input  egsd_pkg::code_t code,
	output egsd_pkg::res_t  res
);

	logic [egsd_pkg::ValueWidth-1:0] half;
	logic [egsd_pkg::ValueWidth-1:0] se_val;
	logic                            small_tab;
	logic                            small_hit;
	logic                            large_hit;
	logic [5:0]                      large_idx;
	logic [3:0]                      small_idx;
	logic [5:0]                      me_val;
	logic [egsd_pkg::LenWidth-1:0]   code_len;

	assign code_len = {code.zeros, 1'b1};

	// Signed mapping: odd k gives (k+1)/2, even k gives -(k/2)
	assign half   = {2'b00, code.code_num[31:1]};
	assign se_val = code.code_num[0] ? (half + 33'd1) : (33'd0 - half);

	// Table selection and range check
	assign small_tab = (chroma_format == egsd_pkg::ChromaMono)
		|| (chroma_format == egsd_pkg::Chroma444);
	assign small_hit = (code.code_num[31:4] == 28'd0);
	assign large_hit = (code.code_num[31:6] == 26'd0) && (code.code_num[5:4] != 2'b11);
	assign small_idx = code.code_num[3:0];
	assign large_idx = code.code_num[5:0];

	always_comb begin
		if (small_tab) begin
			me_val = {2'b00, (inter_column == egsd_pkg::ColIntra)
				? egsd_pkg::CbpSmallIntra[small_idx] : egsd_pkg::CbpSmallInter[small_idx]};
		end else begin
			me_val = (inter_column == egsd_pkg::ColIntra)
				? egsd_pkg::CbpLargeIntra[large_idx] : egsd_pkg::CbpLargeInter[large_idx];
		end
	end

	// Select the value by mode; the one-bit te path ignores the code entirely
	always_comb begin
		res.value      = '0;
		res.bits_used  = code_len;
		res.code_error = 1'b0;
		if ((func == egsd_pkg::FUNC_TE) && (te_range <= 6'd1)) begin
			res.value     = {32'd0, ~first_bit};
			res.bits_used = 6'd1;
		end else if (code.overflow) begin
			res.bits_used  = '0;
			res.code_error = 1'b1;
		end else begin
			case (egsd_pkg::func_t'(func))
				egsd_pkg::FUNC_SE: res.value = se_val;
				egsd_pkg::FUNC_ME: begin
					if ((small_tab && small_hit) || (!small_tab && large_hit)) begin
						res.value = {27'd0, me_val};
					end else begin
						res.code_error = 1'b1;
					end
				end
				default: res.value = {1'b0, code.code_num};
			endcase
		end
	end

endmodule

[rtl/core/exp_golomb_syntax_decoder.sv]
// Exp-Golomb (ue/se/te/me) syntax element decoder, top level.
// Throughput one beat per cycle while the sink is ready; the result beat is registered.
// The single compute stage (leading-zero count, 64-bit code shift, decrement, mode map)
// sets the clock period; an input register and a result register bound it.
// Reset (arst_n low, asynchronous) empties both stages; payload registers are not reset.
// Depends on egsd_pkg, egsd_in_if, egsd_out_if, egsd_codenum and egsd_map.
module exp_golomb_syntax_decoder (
	input logic         clk,
	input logic         arst_n,
	egsd_in_if.sink     req,
	egsd_out_if.source  rsp
);

	logic                             v_s1;
	logic [1:0]                       func_s1;
	logic [egsd_pkg::WindowWidth-1:0] win_s1;
	logic [5:0]                       te_range_s1;
	logic [1:0]                       chroma_s1;
	logic                             inter_s1;
	logic                             out_v_q;
	egsd_pkg::res_t                   res_q;
	egsd_pkg::code_t                  code;
	egsd_pkg::res_t                   res_d;
	logic                             adv_out;

	// Flow control: the result register frees when empty or taken
	assign adv_out   = !out_v_q || rsp.ready;
	assign req.ready = !v_s1 || adv_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (req.ready) begin
				v_s1 <= req.valid;
			end
			if (adv_out) begin
				out_v_q <= v_s1;
			end
		end
	end

	// Capture the request beat
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			func_s1     <= req.func;
			win_s1      <= req.bit_window;
			te_range_s1 <= req.te_range;
			chroma_s1   <= req.chroma_format;
			inter_s1    <= req.inter_column;
		end
	end

	egsd_codenum u_codenum (
		.bit_window (win_s1),
		.code       (code)
	);

	egsd_map u_map (
		.func          (func_s1),
		.te_range      (te_range_s1),
		.chroma_format (chroma_s1),
		.inter_column  (inter_s1),
		.first_bit     (win_s1[egsd_pkg::WindowWidth-1]),
		.code          (code),
		.res           (res_d)
	);

	// Hold the result until the sink takes it
	always_ff @(posedge clk) begin
		if (adv_out && v_s1) begin
			res_q <= res_d;
		end
	end

	assign rsp.valid      = out_v_q;
	assign rsp.value      = res_q.value;
	assign rsp.bits_used  = res_q.bits_used;
	assign rsp.code_error = res_q.code_error;

`ifndef SYNTH
	a_err_zero_value: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.code_error |-> rsp.value == '0)
		else $error("errored result carries a non-zero value");

	a_odd_length: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.code_error |-> rsp.bits_used[0])
		else $error("good code with an even length");

	a_negative_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.value[egsd_pkg::ValueWidth-1] |->
			!rsp.code_error && rsp.bits_used != 6'd1)
		else $error("negative value on an error or one-bit code");

	a_stage_fill: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> v_s1)
		else $error("accepted beat lost from the input stage");

	a_stage_drain: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && adv_out |=> out_v_q)
		else $error("input stage advanced without filling the result register");
`endif

endmodule

[tb/testbench.sv]
// Self-checking testbench for the exp-Golomb syntax element decoder (ue/se/te/me).
// Drives request beats from a queue, predicts each element and checks every result beat.
// Depends on egsd_pkg, egsd_in_if, egsd_out_if and exp_golomb_syntax_decoder.
`timescale 1ns / 100ps

module testbench;

	localparam int RandomItems = 1725;
	localparam int CycleLimit  = 200000;
	localparam int DrainCycles = 8;

	// Coded-block-pattern tables: {intra, inter} per code number
	localparam int CBP_LARGE [48][2] = '{
		'{47, 0}, '{31, 16}, '{15, 1}, '{0, 2}, '{23, 4}, '{27, 8}, '{29, 32}, '{30, 3},
		'{7, 5}, '{11, 10}, '{13, 12}, '{14, 15}, '{39, 47}, '{43, 7}, '{45, 11},
		'{46, 13}, '{16, 14}, '{3, 6}, '{5, 9}, '{10, 31}, '{12, 35}, '{19, 37},
		'{21, 42}, '{26, 44}, '{28, 33}, '{35, 34}, '{37, 36}, '{42, 40}, '{44, 39},
		'{1, 43}, '{2, 45}, '{4, 46}, '{8, 17}, '{17, 18}, '{18, 20}, '{20, 24},
		'{24, 19}, '{6, 21}, '{9, 26}, '{22, 28}, '{25, 23}, '{32, 27}, '{33, 29},
		'{34, 30}, '{36, 22}, '{40, 25}, '{38, 38}, '{41, 41}
	};
	localparam int CBP_SMALL [16][2] = '{
		'{15, 0}, '{0, 1}, '{7, 2}, '{11, 4}, '{13, 8}, '{14, 3}, '{3, 5}, '{5, 10},
		'{10, 12}, '{12, 15}, '{1, 7}, '{2, 11}, '{4, 13}, '{8, 14}, '{6, 6}, '{9, 9}
	};

	typedef struct {
		egsd_pkg::func_t func;
		logic [63:0]     window;
		logic [5:0]      range;
		logic [1:0]      chroma;
		logic            column;
	} syntax_req_t;

	typedef struct {
		logic [egsd_pkg::ValueWidth-1:0] value;
		logic [egsd_pkg::LenWidth-1:0]   bits_used;
		logic                            code_error;
	} element_t;

	logic clk;
	logic arst_n;

	egsd_in_if  req_if ();
	egsd_out_if rsp_if ();

	exp_golomb_syntax_decoder dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	syntax_req_t pending_reqs [$];
	element_t    expected_elems [$];
	int          queued_count   = 0;
	int          accepted_count = 0;
	int          fail_count     = 0;
	int          cycle_count    = 0;
	int          send_idle_pct  = 0;
	int          recv_stall_pct = 0;

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// Predict one decoded element from a request beat
	function automatic element_t decode_element(logic [1:0] func, logic [63:0] window,
			logic [5:0] range, logic [1:0] chroma, logic column);
		element_t    e;
		int          zeros;
		logic [63:0] code_num;
		logic [63:0] wide;
		bit          small_tab;
		e.value      = '0;
		e.bits_used  = '0;
		e.code_error = 1'b0;
		// te with range 0 or 1: one inverted bit
		if (func == egsd_pkg::FUNC_TE && range <= 6'd1) begin
			e.value     = window[63] ? 33'd0 : 33'd1;
			e.bits_used = 6'd1;
			return e;
		end
		zeros = 0;
		while (zeros < 64 && window[63 - zeros] == 1'b0)
			zeros++;
		// too many leading zeros: nothing consumed
		if (zeros > 31) begin
			e.code_error = 1'b1;
			return e;
		end
		code_num    = (window >> (63 - 2 * zeros)) - 64'd1;
		e.bits_used = egsd_pkg::LenWidth'(2 * zeros + 1);
		case (func)
			egsd_pkg::FUNC_SE: begin
				if (code_num[0])
					wide = (code_num + 64'd1) >> 1;
				else
					wide = 64'd0 - (code_num >> 1);
				e.value = wide[egsd_pkg::ValueWidth-1:0];
			end
			egsd_pkg::FUNC_ME: begin
				small_tab = (chroma == egsd_pkg::ChromaMono || chroma == egsd_pkg::Chroma444);
				if (small_tab && code_num < 64'(egsd_pkg::SmallTableSize))
					e.value = egsd_pkg::ValueWidth'(CBP_SMALL[code_num[3:0]][column]);
				else if (!small_tab && code_num < 64'(egsd_pkg::LargeTableSize))
					e.value = egsd_pkg::ValueWidth'(CBP_LARGE[code_num[5:0]][column]);
				else
					e.code_error = 1'b1;
			end
			default: e.value = code_num[egsd_pkg::ValueWidth-1:0];
		endcase
		return e;
	endfunction

	// Window carrying exactly the given number of leading zeros, then a one, then tail bits
	function automatic logic [63:0] zeros_window(int zeros, logic [63:0] tail);
		logic [63:0] w;
		if (zeros >= 64)
			return 64'd0;
		w = tail & ({64{1'b1}} >> zeros);
		w[63 - zeros] = 1'b1;
		return w;
	endfunction

	// Window whose leading code has the given code number
	function automatic logic [63:0] code_window(logic [63:0] code_num, logic [63:0] tail);
		int          zeros;
		logic [63:0] code;
		logic [63:0] low_mask;
		code  = code_num + 64'd1;
		zeros = 0;
		while ((code >> (zeros + 1)) != 64'd0)
			zeros++;
		low_mask = (64'd1 << (63 - 2 * zeros)) - 64'd1;
		return (code << (63 - 2 * zeros)) | (tail & low_mask);
	endfunction

	function automatic logic [63:0] rand_word();
		return {$urandom, $urandom};
	endfunction

	task automatic queue_req(egsd_pkg::func_t func, logic [63:0] window, logic [5:0] range,
			logic [1:0] chroma, logic column);
		syntax_req_t r;
		r.func   = func;
		r.window = window;
		r.range  = range;
		r.chroma = chroma;
		r.column = column;
		pending_reqs.push_back(r);
		queued_count++;
	endtask

	// Hold until every queued beat is accepted and every result is back
	task automatic wait_drained();
		while (pending_reqs.size() != 0 || accepted_count != queued_count ||
				expected_elems.size() != 0)
			@(posedge clk);
	endtask

	task automatic queue_random(int count);
		int              sel;
		int              zeros;
		egsd_pkg::func_t func;
		logic [63:0]     window;
		logic [5:0]      range;
		for (int i = 0; i < count; i++) begin
			func = egsd_pkg::func_t'($urandom_range(3));
			sel  = $urandom_range(99);
			if (sel < 3)
				window = 64'd0;
			else if (sel < 10)
				window = rand_word();
			else if (sel < 16)
				window = zeros_window($urandom_range(63, 32), rand_word());
			else begin
				// me codes stay mostly inside or just past the tables
				if (func == egsd_pkg::FUNC_ME && $urandom_range(9) < 8)
					zeros = $urandom_range(6);
				else
					zeros = $urandom_range(31);
				window = zeros_window(zeros, rand_word());
			end
			range = ($urandom_range(1)) ? 6'($urandom_range(1)) : 6'($urandom_range(63));
			queue_req(func, window, range, 2'($urandom_range(3)), 1'($urandom_range(1)));
		end
	endtask

	// Driver: present the next beat, record an expectation on each accepted beat
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_if.valid         <= 1'b0;
			req_if.func          <= egsd_pkg::FUNC_UE;
			req_if.bit_window    <= '0;
			req_if.te_range      <= '0;
			req_if.chroma_format <= '0;
			req_if.inter_column  <= 1'b0;
		end else begin
			if (req_if.valid && req_if.ready) begin
				expected_elems.push_back(decode_element(req_if.func, req_if.bit_window,
					req_if.te_range, req_if.chroma_format, req_if.inter_column));
				accepted_count++;
			end
			if (!req_if.valid || req_if.ready) begin
				if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					req_if.valid         <= 1'b1;
					req_if.func          <= pending_reqs[0].func;
					req_if.bit_window    <= pending_reqs[0].window;
					req_if.te_range      <= pending_reqs[0].range;
					req_if.chroma_format <= pending_reqs[0].chroma;
					req_if.inter_column  <= pending_reqs[0].column;
					void'(pending_reqs.pop_front());
				end else begin
					req_if.valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: compare each result beat with the oldest expectation, stall at random
	always @(posedge clk or negedge arst_n) begin : check_proc
		element_t exp_e;
		if (!arst_n) begin
			rsp_if.ready <= 1'b0;
		end else begin
			if (rsp_if.valid && rsp_if.ready) begin
				if (expected_elems.size() == 0) begin
					$error("result beat with no expectation: value=%h bits_used=%0d err=%b",
						rsp_if.value, rsp_if.bits_used, rsp_if.code_error);
					fail_count++;
				end else begin
					exp_e = expected_elems.pop_front();
					if (rsp_if.value !== exp_e.value) begin
						$error("value: expected %h, actual %h", exp_e.value, rsp_if.value);
						fail_count++;
					end
					if (rsp_if.bits_used !== exp_e.bits_used) begin
						$error("bits_used: expected %0d, actual %0d",
							exp_e.bits_used, rsp_if.bits_used);
						fail_count++;
					end
					if (rsp_if.code_error !== exp_e.code_error) begin
						$error("code_error: expected %b, actual %b",
							exp_e.code_error, rsp_if.code_error);
						fail_count++;
					end
				end
			end
			rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CycleLimit) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		arst_n               = 1'b0;
		req_if.valid         = 1'b0;
		req_if.func          = egsd_pkg::FUNC_UE;
		req_if.bit_window    = '0;
		req_if.te_range      = '0;
		req_if.chroma_format = '0;
		req_if.inter_column  = 1'b0;
		rsp_if.ready         = 1'b0;

		// Directed: zero windows, longest codes, every mode and table edge
		queue_req(egsd_pkg::FUNC_UE, 64'd0, 6'd5, 2'd0, 1'b0);
		queue_req(egsd_pkg::FUNC_SE, 64'd0, 6'd5, 2'd1, 1'b1);
		queue_req(egsd_pkg::FUNC_ME, 64'd0, 6'd5, 2'd2, 1'b0);
		queue_req(egsd_pkg::FUNC_TE, 64'd0, 6'd63, 2'd3, 1'b1);
		queue_req(egsd_pkg::FUNC_TE, 64'd0, 6'd0, 2'd0, 1'b0);
		queue_req(egsd_pkg::FUNC_TE, {64{1'b1}}, 6'd1, 2'd0, 1'b1);
		queue_req(egsd_pkg::FUNC_TE, {64{1'b1}}, 6'd2, 2'd0, 1'b1);
		queue_req(egsd_pkg::FUNC_UE, {64{1'b1}}, 6'd0, 2'd0, 1'b0);
		queue_req(egsd_pkg::FUNC_UE, code_window(64'hFFFF_FFFE, {64{1'b1}}), 6'd0, 2'd0,
			1'b0);
		queue_req(egsd_pkg::FUNC_SE, code_window(64'hFFFF_FFFE, 64'd0), 6'd0, 2'd0, 1'b0);
		queue_req(egsd_pkg::FUNC_SE, code_window(64'hFFFF_FFFD, 64'd0), 6'd0, 2'd0, 1'b0);
		queue_req(egsd_pkg::FUNC_UE, zeros_window(32, {64{1'b1}}), 6'd0, 2'd0, 1'b0);
		queue_req(egsd_pkg::FUNC_UE, 64'd1, 6'd0, 2'd0, 1'b0);
		queue_req(egsd_pkg::FUNC_SE, code_window(64'd0, 64'd0), 6'd0, 2'd0, 1'b0);
		queue_req(egsd_pkg::FUNC_SE, code_window(64'd1, 64'd0), 6'd0, 2'd0, 1'b0);
		queue_req(egsd_pkg::FUNC_SE, code_window(64'd2, {64{1'b1}}), 6'd0, 2'd0, 1'b0);
		queue_req(egsd_pkg::FUNC_TE, code_window(64'd5, rand_word()), 6'd2, 2'd0, 1'b0);
		queue_req(egsd_pkg::FUNC_ME, code_window(64'd15, rand_word()), 6'd0, 2'd0, 1'b0);
		queue_req(egsd_pkg::FUNC_ME, code_window(64'd15, rand_word()), 6'd0, 2'd3, 1'b1);
		queue_req(egsd_pkg::FUNC_ME, code_window(64'd16, rand_word()), 6'd0, 2'd3, 1'b0);
		queue_req(egsd_pkg::FUNC_ME, code_window(64'd16, rand_word()), 6'd0, 2'd1, 1'b1);
		queue_req(egsd_pkg::FUNC_ME, code_window(64'd47, rand_word()), 6'd0, 2'd2, 1'b0);
		queue_req(egsd_pkg::FUNC_ME, code_window(64'd47, rand_word()), 6'd0, 2'd1, 1'b1);
		queue_req(egsd_pkg::FUNC_ME, code_window(64'd48, rand_word()), 6'd0, 2'd2, 1'b1);
		queue_req(egsd_pkg::FUNC_ME, code_window(64'hFFFF_FFFE, 64'd0), 6'd0, 2'd0, 1'b1);

		// Phase one: light sender gaps, heavy receiver stalls
		send_idle_pct  = 14;
		recv_stall_pct = 52;
		queue_random(RandomItems / 3);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		wait_drained();

		// Phase two: roles swapped
		send_idle_pct  = 52;
		recv_stall_pct = 14;
		queue_random(RandomItems / 3);
		wait_drained();

		// Phase three: full rate on both sides
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		queue_random(RandomItems - 2 * (RandomItems / 3));
		wait_drained();

		repeat (DrainCycles) @(posedge clk);
		if (fail_count == 0 && expected_elems.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
